FILE: rtl/pqe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pqe_pkg: shared types and constants of the particle quad expander
// Field widths, angle constants, corner and quadrant codes, the item that
// travels from the classifier to the vertex generator, and the sine table.
// ----------------------------------------------------------------------------
package pqe_pkg;

  localparam int POS_W            = 24;
  localparam int SIDE_W           = 20;
  localparam int ANGLE_W          = 13;
  localparam int COLOR_IN_W       = 9;
  localparam int COLOR_W          = 8;
  localparam int COLOR_MAX        = 255;

  localparam int TRIG_FRAC_BITS   = 15;
  localparam int SINE_TABLE_DEPTH = 1024;

  localparam int DEG_QUARTER      = 1440;
  localparam int DEG_FULL         = 4 * DEG_QUARTER;

  // Phase within a quadrant, including the mirrored phase of a full quarter.
  localparam int PHASE_W  = $clog2(DEG_QUARTER + 1);
  localparam int IDX_W    = $clog2(SINE_TABLE_DEPTH + 1);
  // Numerator of the nearest-entry lookup: phase*depth + quarter/2.
  localparam int NUM_W    = $clog2(DEG_QUARTER * SINE_TABLE_DEPTH + DEG_QUARTER / 2 + 1);
  // floor(2^NUM_W / quarter): the estimate is low by at most one.
  localparam int RECIP    = (1 << NUM_W) / DEG_QUARTER;
  localparam int RECIP_W  = $clog2(RECIP + 1);

  localparam int MAG_W    = TRIG_FRAC_BITS + 1;
  localparam int TRIG_W   = TRIG_FRAC_BITS + 2;
  localparam int PROD_W   = SIDE_W + 1 + TRIG_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int RND_W    = SUM_W + 1;
  localparam int OFS_SHIFT = TRIG_FRAC_BITS + 1;
  localparam int OFS_W    = RND_W - OFS_SHIFT;
  localparam int VSUM_W   = ((OFS_W > POS_W) ? OFS_W : POS_W) + 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;
  localparam int          TAYLOR_TERMS = 12;

  typedef enum logic [1:0] {
    CORNER_BL,
    CORNER_BR,
    CORNER_TL,
    CORNER_TR
  } corner_t;

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_1,
    QUAD_2,
    QUAD_3
  } quad_t;

  typedef struct packed {
    logic signed [POS_W-1:0] centre_x;
    logic signed [POS_W-1:0] centre_y;
    logic [SIDE_W-1:0]       side_len;
    quad_t                   quad;
    logic [IDX_W-1:0]        sin_idx;
    logic [IDX_W-1:0]        cos_idx;
    logic [COLOR_W-1:0]      red;
    logic [COLOR_W-1:0]      green;
    logic [COLOR_W-1:0]      blue;
    logic [COLOR_W-1:0]      alpha;
  } pqe_item_t;

  typedef logic [MAG_W-1:0] sine_tab_t [SINE_TABLE_DEPTH+1];

  // Quarter-wave sine in Q1.TRIG_FRAC_BITS, from a Q30 Taylor series,
  // rounded half up and clamped to one. Evaluated at elaboration only.
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t          tab;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        e;
    logic signed [63:0] sum;
    logic [63:0]        one;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x    = (64'(k) * HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      one  = 64'd1 << TRIG_FRAC_BITS;
      for (int n = 1; n <= TAYLOR_TERMS; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if ((n & 1) != 0) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = '0;
      end
      e = ($unsigned(sum) + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
      if (e > one || k == SINE_TABLE_DEPTH) begin
        e = one;
      end
      tab[k] = e[MAG_W-1:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage
`default_nettype wire

FILE: rtl/pqe_particle_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pqe_particle_if: particle input channel
// One particle per transfer: center, side length, angle and color.
// ----------------------------------------------------------------------------
interface pqe_particle_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [pqe_pkg::POS_W-1:0]         centre_x;
  logic signed [pqe_pkg::POS_W-1:0]         centre_y;
  logic [pqe_pkg::SIDE_W-1:0]               side_len;
  logic [pqe_pkg::ANGLE_W-1:0]              angle_sixteenths;
  logic [pqe_pkg::COLOR_IN_W-1:0]           red_in;
  logic [pqe_pkg::COLOR_IN_W-1:0]           green_in;
  logic [pqe_pkg::COLOR_IN_W-1:0]           blue_in;
  logic [pqe_pkg::COLOR_IN_W-1:0]           alpha_in;

  modport source (
    output valid, centre_x, centre_y, side_len, angle_sixteenths,
           red_in, green_in, blue_in, alpha_in,
    input  ready
  );

  modport sink (
    input  valid, centre_x, centre_y, side_len, angle_sixteenths,
           red_in, green_in, blue_in, alpha_in,
    output ready
  );
endinterface
`default_nettype wire

FILE: rtl/pqe_vertex_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pqe_vertex_if: vertex output channel
// One quad corner per transfer: position, texture corner and colour bytes.
// ----------------------------------------------------------------------------
interface pqe_vertex_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        corner_id;
  logic signed [pqe_pkg::POS_W-1:0]  vert_x;
  logic signed [pqe_pkg::POS_W-1:0]  vert_y;
  logic                              tex_u;
  logic                              tex_v;
  logic [pqe_pkg::COLOR_W-1:0]       red_out;
  logic [pqe_pkg::COLOR_W-1:0]       green_out;
  logic [pqe_pkg::COLOR_W-1:0]       blue_out;
  logic [pqe_pkg::COLOR_W-1:0]       alpha_out;
  logic                              last_corner;

  modport source (
    output valid, corner_id, vert_x, vert_y, tex_u, tex_v,
           red_out, green_out, blue_out, alpha_out, last_corner,
    input  ready
  );

  modport sink (
    input  valid, corner_id, vert_x, vert_y, tex_u, tex_v,
           red_out, green_out, blue_out, alpha_out, last_corner,
    output ready
  );
endinterface
`default_nettype wire

FILE: rtl/pqe_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pqe_front: particle classifier
// Wraps the angle, splits it into quadrant and phase, finds the sine and
// cosine table entries and converts the color to bytes. Two register stages.
// ----------------------------------------------------------------------------
module pqe_front (
  input  wire logic           clk,
  input  wire logic           rst,
  pqe_particle_if.sink        particle,
  output pqe_pkg::pqe_item_t  push_item,
  output logic                push_valid,
  input  wire logic           push_ready
);

  localparam int MUL_W  = pqe_pkg::NUM_W + pqe_pkg::RECIP_W;
  localparam int CPROD_W = pqe_pkg::COLOR_IN_W + pqe_pkg::COLOR_W;

  function automatic logic [pqe_pkg::COLOR_W-1:0] to_byte(
    input logic [pqe_pkg::COLOR_IN_W-1:0] c
  );
    logic [CPROD_W-1:0]              prod;
    logic [pqe_pkg::COLOR_IN_W-1:0]  scaled;
    prod   = (CPROD_W'(c) << pqe_pkg::COLOR_W) - CPROD_W'(c);
    scaled = prod[CPROD_W-1:pqe_pkg::COLOR_W];
    if (scaled > pqe_pkg::COLOR_IN_W'(pqe_pkg::COLOR_MAX)) begin
      return '1;
    end
    return scaled[pqe_pkg::COLOR_W-1:0];
  endfunction

  logic [pqe_pkg::ANGLE_W-1:0]  ang_wrap;
  pqe_pkg::quad_t               quad;
  logic [pqe_pkg::ANGLE_W-1:0]  phase_full;
  logic [pqe_pkg::PHASE_W-1:0]  phase;
  pqe_pkg::pqe_item_t           base;
  logic [pqe_pkg::NUM_W-1:0]    num_sin;
  logic [pqe_pkg::NUM_W-1:0]    num_cos;

  logic                         f1_valid;
  pqe_pkg::pqe_item_t           f1_item;
  logic [pqe_pkg::NUM_W-1:0]    f1_num_sin;
  logic [pqe_pkg::NUM_W-1:0]    f1_num_cos;

  logic                         f2_valid;
  pqe_pkg::pqe_item_t           f2_item;
  logic [pqe_pkg::NUM_W-1:0]    f2_num_sin;
  logic [pqe_pkg::NUM_W-1:0]    f2_num_cos;
  logic [pqe_pkg::IDX_W-1:0]    f2_est_sin;
  logic [pqe_pkg::IDX_W-1:0]    f2_est_cos;

  logic [MUL_W-1:0]             est_prod_sin;
  logic [MUL_W-1:0]             est_prod_cos;
  logic [pqe_pkg::NUM_W-1:0]    rem_sin;
  logic [pqe_pkg::NUM_W-1:0]    rem_cos;

  logic                         f1_load;
  logic                         f2_load;
  logic                         in_fire;

  // Angles past a full turn are at most one turn too large.
  always_comb begin
    if (particle.angle_sixteenths >= pqe_pkg::ANGLE_W'(pqe_pkg::DEG_FULL)) begin
      ang_wrap = particle.angle_sixteenths - pqe_pkg::ANGLE_W'(pqe_pkg::DEG_FULL);
    end else begin
      ang_wrap = particle.angle_sixteenths;
    end
  end

  always_comb begin
    if (ang_wrap < pqe_pkg::ANGLE_W'(pqe_pkg::DEG_QUARTER)) begin
      quad       = pqe_pkg::QUAD_0;
      phase_full = ang_wrap;
    end else if (ang_wrap < pqe_pkg::ANGLE_W'(2 * pqe_pkg::DEG_QUARTER)) begin
      quad       = pqe_pkg::QUAD_1;
      phase_full = ang_wrap - pqe_pkg::ANGLE_W'(pqe_pkg::DEG_QUARTER);
    end else if (ang_wrap < pqe_pkg::ANGLE_W'(3 * pqe_pkg::DEG_QUARTER)) begin
      quad       = pqe_pkg::QUAD_2;
      phase_full = ang_wrap - pqe_pkg::ANGLE_W'(2 * pqe_pkg::DEG_QUARTER);
    end else begin
      quad       = pqe_pkg::QUAD_3;
      phase_full = ang_wrap - pqe_pkg::ANGLE_W'(3 * pqe_pkg::DEG_QUARTER);
    end
  end

  assign phase = phase_full[pqe_pkg::PHASE_W-1:0];

  // Table lookup numerators; the cosine reads at the mirrored phase.
  assign num_sin = pqe_pkg::NUM_W'(phase) * pqe_pkg::NUM_W'(pqe_pkg::SINE_TABLE_DEPTH)
                 + pqe_pkg::NUM_W'(pqe_pkg::DEG_QUARTER / 2);
  assign num_cos = (pqe_pkg::NUM_W'(pqe_pkg::DEG_QUARTER) - pqe_pkg::NUM_W'(phase))
                 * pqe_pkg::NUM_W'(pqe_pkg::SINE_TABLE_DEPTH)
                 + pqe_pkg::NUM_W'(pqe_pkg::DEG_QUARTER / 2);

  always_comb begin
    base          = '0;
    base.centre_x = particle.centre_x;
    base.centre_y = particle.centre_y;
    base.side_len = particle.side_len;
    base.quad     = quad;
    base.red      = to_byte(particle.red_in);
    base.green    = to_byte(particle.green_in);
    base.blue     = to_byte(particle.blue_in);
    base.alpha    = to_byte(particle.alpha_in);
  end

  // Division by the quarter turn: reciprocal estimate, then one correction.
  assign est_prod_sin = MUL_W'(f1_num_sin) * MUL_W'(pqe_pkg::RECIP);
  assign est_prod_cos = MUL_W'(f1_num_cos) * MUL_W'(pqe_pkg::RECIP);

  assign rem_sin = f2_num_sin
                 - pqe_pkg::NUM_W'(f2_est_sin) * pqe_pkg::NUM_W'(pqe_pkg::DEG_QUARTER);
  assign rem_cos = f2_num_cos
                 - pqe_pkg::NUM_W'(f2_est_cos) * pqe_pkg::NUM_W'(pqe_pkg::DEG_QUARTER);

  always_comb begin
    push_item = f2_item;
    push_item.sin_idx = f2_est_sin
      + pqe_pkg::IDX_W'(rem_sin >= pqe_pkg::NUM_W'(pqe_pkg::DEG_QUARTER));
    push_item.cos_idx = f2_est_cos
      + pqe_pkg::IDX_W'(rem_cos >= pqe_pkg::NUM_W'(pqe_pkg::DEG_QUARTER));
  end

  assign push_valid     = f2_valid;
  assign f2_load        = !f2_valid || push_ready;
  assign f1_load        = !f1_valid || f2_load;
  assign particle.ready = f1_load;
  assign in_fire        = particle.valid && f1_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
    end else begin
      if (f1_load) begin
        f1_valid <= particle.valid;
      end
      if (f2_load) begin
        f2_valid <= f1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      f1_item    <= base;
      f1_num_sin <= num_sin;
      f1_num_cos <= num_cos;
    end
    if (f2_load && f1_valid) begin
      f2_item    <= f1_item;
      f2_num_sin <= f1_num_sin;
      f2_num_cos <= f1_num_cos;
      f2_est_sin <= est_prod_sin[pqe_pkg::NUM_W +: pqe_pkg::IDX_W];
      f2_est_cos <= est_prod_cos[pqe_pkg::NUM_W +: pqe_pkg::IDX_W];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/pqe_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pqe_queue: item queue between classifier and vertex generator
// A short first-in first-out buffer so that either side may stall alone.
// ----------------------------------------------------------------------------
module pqe_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire pqe_pkg::pqe_item_t   push_item,
  input  wire logic                 push_valid,
  output logic                      push_ready,
  output pqe_pkg::pqe_item_t        pop_item,
  output logic                      pop_valid,
  input  wire logic                 pop_ready
);

  pqe_pkg::pqe_item_t           entries [pqe_pkg::QUEUE_DEPTH];
  logic [pqe_pkg::QPTR_W-1:0]   wr_ptr;
  logic [pqe_pkg::QPTR_W-1:0]   rd_ptr;
  logic [pqe_pkg::QPTR_W-1:0]   ptr_diff;
  logic [pqe_pkg::QCNT_W-1:0]   count;
  logic                         push;
  logic                         pop;

  assign push_ready = count != pqe_pkg::QCNT_W'(pqe_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_item   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign ptr_diff   = wr_ptr - rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    count <= pqe_pkg::QCNT_W'(pqe_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not follow a lone push");

  assert property (@(posedge clk) disable iff (rst)
    count == pqe_pkg::QCNT_W'(ptr_diff)
    || (count == pqe_pkg::QCNT_W'(pqe_pkg::QUEUE_DEPTH) && wr_ptr == rd_ptr))
    else $error("queue pointers disagree with count");

endmodule
`default_nettype wire

FILE: rtl/pqe_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pqe_back: vertex generator
// Reads sine and cosine, applies quadrant signs, scales by the side length,
// then steps through the four corners, one vertex per cycle when unstalled.
// ----------------------------------------------------------------------------
module pqe_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire pqe_pkg::pqe_item_t   pop_item,
  input  wire logic                 pop_valid,
  output logic                      pop_ready,
  pqe_vertex_if.source              vertex
);

  localparam logic signed [pqe_pkg::RND_W-1:0] HALF_ULP =
    pqe_pkg::RND_W'(1) << pqe_pkg::TRIG_FRAC_BITS;

  function automatic logic signed [pqe_pkg::POS_W-1:0] sat_pos(
    input logic signed [pqe_pkg::VSUM_W-1:0] v
  );
    logic [pqe_pkg::VSUM_W-pqe_pkg::POS_W:0] top;
    top = v[pqe_pkg::VSUM_W-1:pqe_pkg::POS_W-1];
    if ((&top) || !(|top)) begin
      return v[pqe_pkg::POS_W-1:0];
    end
    if (v[pqe_pkg::VSUM_W-1]) begin
      return {1'b1, {(pqe_pkg::POS_W-1){1'b0}}};
    end
    return {1'b0, {(pqe_pkg::POS_W-1){1'b1}}};
  endfunction

  // Stage A: table read
  logic                               a_valid;
  pqe_pkg::pqe_item_t                 a_item;
  logic [pqe_pkg::MAG_W-1:0]          a_sin_mag;
  logic [pqe_pkg::MAG_W-1:0]          a_cos_mag;

  // Stage B: scaled trig products
  logic                               b_valid;
  pqe_pkg::pqe_item_t                 b_item;
  logic signed [pqe_pkg::PROD_W-1:0]  b_pcos;
  logic signed [pqe_pkg::PROD_W-1:0]  b_psin;

  // Stage C: corner sequencer
  logic                               c_valid;
  pqe_pkg::corner_t                   cnt;
  logic signed [pqe_pkg::POS_W-1:0]   c_cx;
  logic signed [pqe_pkg::POS_W-1:0]   c_cy;
  logic signed [pqe_pkg::SUM_W-1:0]   c_spp;
  logic signed [pqe_pkg::SUM_W-1:0]   c_spm;
  logic [pqe_pkg::COLOR_W-1:0]        c_red;
  logic [pqe_pkg::COLOR_W-1:0]        c_green;
  logic [pqe_pkg::COLOR_W-1:0]        c_blue;
  logic [pqe_pkg::COLOR_W-1:0]        c_alpha;

  // Output register
  logic                               o_valid;
  pqe_pkg::corner_t                   o_corner;
  logic signed [pqe_pkg::POS_W-1:0]   o_x;
  logic signed [pqe_pkg::POS_W-1:0]   o_y;
  logic [pqe_pkg::COLOR_W-1:0]        o_red;
  logic [pqe_pkg::COLOR_W-1:0]        o_green;
  logic [pqe_pkg::COLOR_W-1:0]        o_blue;
  logic [pqe_pkg::COLOR_W-1:0]        o_alpha;

  logic signed [pqe_pkg::TRIG_W-1:0]  sin_pos;
  logic signed [pqe_pkg::TRIG_W-1:0]  cos_pos;
  logic signed [pqe_pkg::TRIG_W-1:0]  sn;
  logic signed [pqe_pkg::TRIG_W-1:0]  cs;
  logic signed [pqe_pkg::SIDE_W:0]    side_s;
  logic signed [pqe_pkg::SUM_W-1:0]   tx;
  logic signed [pqe_pkg::SUM_W-1:0]   ty;
  logic signed [pqe_pkg::RND_W-1:0]   rx;
  logic signed [pqe_pkg::RND_W-1:0]   ry;
  logic signed [pqe_pkg::VSUM_W-1:0]  vx;
  logic signed [pqe_pkg::VSUM_W-1:0]  vy;

  logic out_load;
  logic c_fire;
  logic c_done;
  logic c_load;
  logic b_adv;
  logic b_load;
  logic a_adv;
  logic a_load;

  assign out_load  = !o_valid || vertex.ready;
  assign c_fire    = c_valid && out_load;
  assign c_done    = c_fire && cnt == pqe_pkg::CORNER_TR;
  assign c_load    = !c_valid || c_done;
  assign b_adv     = b_valid && c_load;
  assign b_load    = !b_valid || b_adv;
  assign a_adv     = a_valid && b_load;
  assign a_load    = !a_valid || a_adv;
  assign pop_ready = a_load;

  // Quadrant symmetries of sine and cosine.
  assign sin_pos = $signed({1'b0, a_sin_mag});
  assign cos_pos = $signed({1'b0, a_cos_mag});

  always_comb begin
    unique case (a_item.quad)
      pqe_pkg::QUAD_0: begin
        sn = sin_pos;
        cs = cos_pos;
      end
      pqe_pkg::QUAD_1: begin
        sn = cos_pos;
        cs = -sin_pos;
      end
      pqe_pkg::QUAD_2: begin
        sn = -sin_pos;
        cs = -cos_pos;
      end
      default: begin
        sn = -cos_pos;
        cs = sin_pos;
      end
    endcase
  end

  assign side_s = $signed({1'b0, a_item.side_len});

  // With P = side*cos and Q = side*sin, every corner offset is a signed
  // combination of P+Q or P-Q.
  always_comb begin
    unique case (cnt)
      pqe_pkg::CORNER_BL: begin
        tx = -c_spp;
        ty = -c_spm;
      end
      pqe_pkg::CORNER_BR: begin
        tx = c_spm;
        ty = -c_spp;
      end
      pqe_pkg::CORNER_TL: begin
        tx = -c_spm;
        ty = c_spp;
      end
      default: begin
        tx = c_spp;
        ty = c_spm;
      end
    endcase
  end

  // Round half up to a position step; the arithmetic shift floors.
  assign rx = pqe_pkg::RND_W'(tx) + HALF_ULP;
  assign ry = pqe_pkg::RND_W'(ty) + HALF_ULP;
  assign vx = pqe_pkg::VSUM_W'(c_cx)
            + pqe_pkg::VSUM_W'($signed(rx[pqe_pkg::RND_W-1:pqe_pkg::OFS_SHIFT]));
  assign vy = pqe_pkg::VSUM_W'(c_cy)
            + pqe_pkg::VSUM_W'($signed(ry[pqe_pkg::RND_W-1:pqe_pkg::OFS_SHIFT]));

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      cnt     <= pqe_pkg::CORNER_BL;
      o_valid <= 1'b0;
    end else begin
      if (a_load) begin
        a_valid <= pop_valid;
      end
      if (b_load) begin
        b_valid <= a_valid;
      end
      if (c_load) begin
        c_valid <= b_valid;
      end
      if (c_fire) begin
        cnt <= pqe_pkg::corner_t'(cnt + 1'b1);
      end
      if (c_fire) begin
        o_valid <= 1'b1;
      end else if (vertex.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_load && pop_valid) begin
      a_item    <= pop_item;
      a_sin_mag <= pqe_pkg::SINE_TAB[pop_item.sin_idx];
      a_cos_mag <= pqe_pkg::SINE_TAB[pop_item.cos_idx];
    end
    if (a_adv) begin
      b_item <= a_item;
      b_pcos <= side_s * cs;
      b_psin <= side_s * sn;
    end
    if (b_adv) begin
      c_cx    <= b_item.centre_x;
      c_cy    <= b_item.centre_y;
      c_spp   <= pqe_pkg::SUM_W'(b_pcos) + pqe_pkg::SUM_W'(b_psin);
      c_spm   <= pqe_pkg::SUM_W'(b_pcos) - pqe_pkg::SUM_W'(b_psin);
      c_red   <= b_item.red;
      c_green <= b_item.green;
      c_blue  <= b_item.blue;
      c_alpha <= b_item.alpha;
    end
    if (c_fire) begin
      o_corner <= cnt;
      o_x      <= sat_pos(vx);
      o_y      <= sat_pos(vy);
      o_red    <= c_red;
      o_green  <= c_green;
      o_blue   <= c_blue;
      o_alpha  <= c_alpha;
    end
  end

  assign vertex.valid       = o_valid;
  assign vertex.corner_id   = o_corner;
  assign vertex.vert_x      = o_x;
  assign vertex.vert_y      = o_y;
  assign vertex.tex_u       = o_corner[0];
  assign vertex.tex_v       = !o_corner[1];
  assign vertex.red_out     = o_red;
  assign vertex.green_out   = o_green;
  assign vertex.blue_out    = o_blue;
  assign vertex.alpha_out   = o_alpha;
  assign vertex.last_corner = o_corner == pqe_pkg::CORNER_TR;

  assert property (@(posedge clk) disable iff (rst)
    !c_valid |-> cnt == pqe_pkg::CORNER_BL)
    else $error("corner sequencer left mid-particle");

  assert property (@(posedge clk) disable iff (rst)
    c_fire |=> o_valid && o_corner == $past(cnt))
    else $error("corner transfer not captured in output register");

  assert property (@(posedge clk) disable iff (rst)
    (b_valid && !c_load) |=> b_valid && $stable(b_pcos) && $stable(b_psin))
    else $error("stalled products changed");

endmodule
`default_nettype wire

FILE: rtl/particle_quad_expand.sv
`default_nettype none
// ----------------------------------------------------------------------------
// particle_quad_expand: rotated point-sprite quad expansion
// Turns one particle into the four vertices of a rotated, textured square.
// ----------------------------------------------------------------------------
// Each accepted particle yields four vertex transfers in the order
// bottom-left, bottom-right, top-left, top-right; last_corner marks the
// fourth. Sustained throughput is set by the corner sequencer, which places
// one vertex per cycle on the single output channel while it is not
// stalled. A particle may be accepted in every cycle until the four-entry
// queue behind the two-stage classifier fills. From acceptance to the first
// vertex, an item passes the two classifier stages, the queue, the table
// read, the multiply stage, the sequencer and the output register. The sine
// table is constant; there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module particle_quad_expand (
  input  wire logic      clk,
  input  wire logic      rst,
  pqe_particle_if.sink   particle,
  pqe_vertex_if.source   vertex
);

  pqe_pkg::pqe_item_t  push_item;
  logic                push_valid;
  logic                push_ready;
  pqe_pkg::pqe_item_t  pop_item;
  logic                pop_valid;
  logic                pop_ready;

  pqe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .particle   (particle),
    .push_item  (push_item),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  pqe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_item  (push_item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_item   (pop_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  pqe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_item  (pop_item),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .vertex    (vertex)
  );

endmodule
`default_nettype wire
